@@ rtl/led_strip_pixel_buffer_core_macros.svh @@
// ----------------------------------------------------------------------------
// LED strip pixel buffer assertion macros
// Shared property forms for the checker of the pixel buffer.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PIXEL_BUFFER_CORE_MACROS_SVH
`define LED_STRIP_PIXEL_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSPB_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("pixel buffer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSPB_ASSERT_NXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("pixel buffer check failed");

`endif

@@ rtl/lspb_pkg.sv @@
// ----------------------------------------------------------------------------
// LED strip pixel buffer package
// Beat types and command codes shared by the pixel buffer modules.
// ----------------------------------------------------------------------------
package lspb_pkg;

    localparam int unsigned CHAN_W = 8;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_SINGLE = 2'd1,
        CMD_FILL   = 2'd2,
        CMD_AUTO   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [5:0]        pixel_index;
        logic [6:0]        range_start;
        logic [6:0]        range_end;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] intensity;
        logic              end_of_request;
    } item_t;

    typedef struct packed {
        logic [5:0]        led_index;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

endpackage

@@ rtl/lspb_scale.sv @@
// ----------------------------------------------------------------------------
// LED strip pixel buffer brightness scaler
// Scales each color channel by intensity as floor(c * w / 255).
// ----------------------------------------------------------------------------
module lspb_scale (
    input  logic            clk,
    input  lspb_pkg::item_t item,
    output lspb_pkg::color_t color
);
    import lspb_pkg::*;

    logic [2*CHAN_W-1:0] prod_r_reg;
    logic [2*CHAN_W-1:0] prod_g_reg;
    logic [2*CHAN_W-1:0] prod_b_reg;

    // Exact floor division by 255 for any product of two 8-bit values.
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
        logic [2*CHAN_W:0] s;
        s = {1'b0, p} + {{(CHAN_W+1){1'b0}}, p[2*CHAN_W-1:CHAN_W]} + 17'd1;
        return s[2*CHAN_W-1:CHAN_W];
    endfunction

    // The products are registered; the division by 255 follows in the next cycle.
    always_ff @(posedge clk)
    begin
        prod_r_reg <= item.red   * item.intensity;
        prod_g_reg <= item.green * item.intensity;
        prod_b_reg <= item.blue  * item.intensity;
    end

    assign color.red   = div255(prod_r_reg);
    assign color.green = div255(prod_g_reg);
    assign color.blue  = div255(prod_b_reg);

endmodule

@@ rtl/led_strip_pixel_buffer_core.sv @@
// ----------------------------------------------------------------------------
// LED strip pixel buffer core
// Stores one brightness-scaled RGB color per LED and streams the strip out.
// ----------------------------------------------------------------------------
// The item channel (item_valid, item_stall, item) carries one command beat:
// a no-op, a single pixel write, a range fill or an autonomous request.
// The block takes one item at a time; item_stall is high from the cycle
// after acceptance until the item's store update and read-out are issued.
// A range fill writes one pixel at a time through the pixel memory's single
// write port. An item with end_of_request set is followed by a refresh:
// NUM_LEDS pixel beats on the pixel channel (pixel_valid, pixel_stall,
// pixel) in index order, one per cycle when unstalled, each one passing
// through the memory read stage and the output register, and last_pixel
// set on index NUM_LEDS-1.
// When the receiver stalls, the pixel beat holds in the output register and
// the memory read stage behind it holds too; nothing is dropped.
// After reset the strip reads as black: a valid bit per entry, cleared by
// reset, masks entries not yet written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module led_strip_pixel_buffer_core #(
    parameter int NUM_LEDS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  lspb_pkg::item_t  item,
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output lspb_pkg::pixel_t pixel
);
    import lspb_pkg::*;

    localparam int         AW      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [6:0] LEDS_W  = 7'(NUM_LEDS);
    localparam logic [6:0] LAST_W  = 7'(NUM_LEDS - 1);

    // One-hot sequencer: capture, multiply, update, fill sweep, read-out.
    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_MUL     = 5'b00010,
        S_WRITE   = 5'b00100,
        S_FILL    = 5'b01000,
        S_REFRESH = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    item_t   item_reg;
    color_t  color;

    logic [6:0] cursor_reg, cursor_next;
    logic [6:0] rd_ptr_reg, rd_ptr_next;
    logic [6:0] end_sat;

    // Pixel memory and its per-entry valid bits.
    logic [3*CHAN_W-1:0] mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] written_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_re;
    logic [3*CHAN_W-1:0] mem_q_reg;

    // Read stage between the memory and the output register.
    logic       pend_valid_reg;
    logic       pend_ok_reg;
    logic [5:0] pend_idx_reg;
    logic       pend_last_reg;
    logic       move;

    logic   out_valid_reg;
    pixel_t out_reg;

    lspb_scale u_scale (
        .clk   (clk),
        .item  (item_reg),
        .color (color)
    );

    assign item_stall  = (state_reg != S_IDLE);
    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    assign end_sat = (item_reg.range_end > LEDS_W) ? LEDS_W : item_reg.range_end;

    // A pixel moves from the read stage when the output slot is free or leaving.
    assign move   = pend_valid_reg && (!out_valid_reg || !pixel_stall);
    assign mem_re = (state_reg == S_REFRESH) && (!pend_valid_reg || move);

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        rd_ptr_next = rd_ptr_reg;
        mem_we      = 1'b0;
        mem_waddr   = item_reg.pixel_index[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                rd_ptr_next = 7'd0;
                if ((item_reg.cmd == CMD_SINGLE) && ({1'b0, item_reg.pixel_index} < LEDS_W))
                begin
                    mem_we = 1'b1;
                end
                if (item_reg.cmd == CMD_FILL)
                begin
                    cursor_next = item_reg.range_start;
                    state_next  = S_FILL;
                end
                else if (item_reg.end_of_request)
                begin
                    state_next = S_REFRESH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                mem_waddr = cursor_reg[AW-1:0];
                if (cursor_reg < end_sat)
                begin
                    mem_we      = 1'b1;
                    cursor_next = cursor_reg + 7'd1;
                end
                else if (item_reg.end_of_request)
                begin
                    state_next = S_REFRESH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REFRESH:
            begin
                if (mem_re)
                begin
                    if (rd_ptr_reg == LAST_W)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 7'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_reg     <= 7'd0;
            rd_ptr_reg     <= 7'd0;
            written_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            rd_ptr_reg <= rd_ptr_next;
            if (mem_we)
            begin
                written_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!pixel_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and read-stage payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && item_valid)
        begin
            item_reg <= item;
        end
        if (mem_re)
        begin
            pend_ok_reg   <= written_reg[rd_ptr_reg[AW-1:0]];
            pend_idx_reg  <= rd_ptr_reg[5:0];
            pend_last_reg <= (rd_ptr_reg == LAST_W);
        end
        if (move)
        begin
            out_reg.led_index  <= pend_idx_reg;
            out_reg.out_red    <= pend_ok_reg ? mem_q_reg[3*CHAN_W-1:2*CHAN_W] : '0;
            out_reg.out_green  <= pend_ok_reg ? mem_q_reg[2*CHAN_W-1:CHAN_W]   : '0;
            out_reg.out_blue   <= pend_ok_reg ? mem_q_reg[CHAN_W-1:0]          : '0;
            out_reg.last_pixel <= pend_last_reg;
        end
    end

    // Pixel memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {color.red, color.green, color.blue};
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

endmodule

@@ rtl/lspb_checker.sv @@
// ----------------------------------------------------------------------------
// LED strip pixel buffer checker
// Port-level checks of the pixel buffer, attached to the core by bind.
// ----------------------------------------------------------------------------
`include "led_strip_pixel_buffer_core_macros.svh"

module lspb_checker #(
    parameter int NUM_LEDS = 32
) (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             pixel_valid,
    input logic             pixel_stall,
    input lspb_pkg::pixel_t pixel
);
    import lspb_pkg::*;

    localparam logic [5:0] LAST_IDX = 6'(NUM_LEDS - 1);

    logic       item_take;
    logic       pixel_take;
    logic       pixel_wait;
    logic       last_ok;
    logic       run_more;
    logic       step_ok;
    logic [5:0] next_idx_reg;

    assign item_take  = item_valid && !item_stall;
    assign pixel_take = pixel_valid && !pixel_stall;
    assign pixel_wait = pixel_valid && pixel_stall;
    assign last_ok    = pixel.last_pixel == (pixel.led_index == LAST_IDX);
    assign run_more   = pixel_take && !pixel.last_pixel;
    assign step_ok    = pixel.led_index == next_idx_reg;

    // Index that the following beat of a refresh has to carry.
    always_ff @(posedge clk)
    begin
        next_idx_reg <= pixel.led_index + 6'd1;
    end

    // A stalled pixel beat holds until it is taken.
    `LSPB_ASSERT_NXT(a_pixel_hold, clk, rst_n, pixel_wait, pixel_valid && $stable(pixel))

    // The block works on one item at a time.
    `LSPB_ASSERT_NXT(a_busy_after_take, clk, rst_n, item_take, item_stall)

    // The last flag marks the final strip index only.
    `LSPB_ASSERT_IMP(a_last_index, clk, rst_n, pixel_valid, last_ok)

    // Within a refresh the next pixel follows at once with the next index.
    `LSPB_ASSERT_NXT(a_run_steps, clk, rst_n, run_more, pixel_valid && step_ok)

endmodule

bind led_strip_pixel_buffer_core lspb_checker #(.NUM_LEDS(NUM_LEDS)) u_lspb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
);
